[design/ppb_pkg.sv]
// Shared constants and types for the photon projection binning block.
package ppb_pkg;

  localparam int FRAME_X_DEF    = 256;
  localparam int FRAME_Y_DEF    = 256;
  localparam int COMPONENTS_DEF = 8;
  localparam int COEF_FRAC_DEF  = 24;
  localparam int ACC_WIDTH_DEF  = 48;

  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  localparam logic [2:0] REG_COEF_U_X = 3'd0;
  localparam logic [2:0] REG_COEF_U_Y = 3'd1;
  localparam logic [2:0] REG_COEF_U_Z = 3'd2;
  localparam logic [2:0] REG_COEF_V_X = 3'd3;
  localparam logic [2:0] REG_COEF_V_Y = 3'd4;
  localparam logic [2:0] REG_COEF_V_Z = 3'd5;
  localparam logic [2:0] REG_OFFSET_U = 3'd6;
  localparam logic [2:0] REG_OFFSET_V = 3'd7;

  localparam logic CMD_DETECT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef struct packed {
    logic signed [31:0] u_x;
    logic signed [31:0] u_y;
    logic signed [31:0] u_z;
    logic signed [31:0] v_x;
    logic signed [31:0] v_y;
    logic signed [31:0] v_z;
    logic signed [55:0] off_u;
    logic signed [55:0] off_v;
  } proj_cfg_t;

endpackage

[design/photon_projection_binning.sv]
// Top level of the photon projection binning block.
// Input channel (valid/ready): one transaction is either a detect command
// (position, luminosity, transmission, stellar flag, component) or a read
// command (frame and pixel). Each transaction yields exactly one result on
// the output channel (valid/ready): hit, pixel_index, saturated for a detect,
// frame_value for a read, in input order.
// The path from input to output runs through four front stages (multiply,
// sum, offset and floor, address), the queue, the frame memory read and the
// accumulate/write stage feeding the output register. One transaction is taken
// every cycle while ready is high; successive hits on the same pixel are
// forwarded past the registered memory read.
// After reset the frames are cleared, one component-frame word per cycle
// (the total frame alongside), over all COMPONENTS*FRAME_X*FRAME_Y cells;
// ready stays low until then. Configuration writes are taken at any time.
// When the receiver stalls the output register holds, the back end stops and
// the eight-entry queue fills; ready drops once queue and front stages
// together would reach eight.
module photon_projection_binning
  import ppb_pkg::*;
#(
  parameter int FRAME_X    = FRAME_X_DEF,
  parameter int FRAME_Y    = FRAME_Y_DEF,
  parameter int COMPONENTS = COMPONENTS_DEF,
  parameter int COEF_FRAC  = COEF_FRAC_DEF,
  parameter int ACC_WIDTH  = ACC_WIDTH_DEF
)
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cmd,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic signed [23:0] pos_z,
  input  logic [31:0]       luminosity,
  input  logic [16:0]       transmission,
  input  logic              is_stellar,
  input  logic [2:0]        component,
  input  logic [3:0]        read_frame,
  input  logic [15:0]       read_pixel,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              hit,
  output logic [15:0]       pixel_index,
  output logic [47:0]       frame_value,
  output logic              saturated
);

  localparam int NPIX   = FRAME_X * FRAME_Y;
  localparam int NCELL  = COMPONENTS * NPIX;
  localparam int TW     = (NPIX > 1) ? $clog2(NPIX) : 1;
  localparam int CW     = (NCELL > 1) ? $clog2(NCELL) : 1;
  localparam int ITEM_W = 4 + 16 + TW + CW + 33;
  localparam int QDEPTH = 8;

  proj_cfg_t         cfg;
  logic              take, push, pop, clearing;
  logic [2:0]        in_flight;
  logic [ITEM_W-1:0] push_item, head;
  logic [3:0]        qcount;

  assign pready   = 1'b1;
  assign in_ready = !clearing && ((5'(qcount) + 5'(in_flight)) < 5'(QDEPTH));
  assign take     = in_valid && in_ready;

  ppb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  ppb_front #(
    .FRAME_X    (FRAME_X),
    .FRAME_Y    (FRAME_Y),
    .COMPONENTS (COMPONENTS),
    .COEF_FRAC  (COEF_FRAC)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .take         (take),
    .cmd          (cmd),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .luminosity   (luminosity),
    .transmission (transmission),
    .is_stellar   (is_stellar),
    .component    (component),
    .read_frame   (read_frame),
    .read_pixel   (read_pixel),
    .in_flight    (in_flight),
    .push         (push),
    .push_item    (push_item)
  );

  ppb_fifo #(
    .W     (ITEM_W),
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_item),
    .pop       (pop),
    .head      (head),
    .count     (qcount)
  );

  ppb_back #(
    .FRAME_X    (FRAME_X),
    .FRAME_Y    (FRAME_Y),
    .COMPONENTS (COMPONENTS),
    .ACC_WIDTH  (ACC_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .avail       (qcount != 4'd0),
    .head        (head),
    .pop         (pop),
    .clearing    (clearing),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .pixel_index (pixel_index),
    .frame_value (frame_value),
    .saturated   (saturated)
  );

endmodule

[design/ppb_regs.sv]
// Configuration register file on the APB-style port.
module ppb_regs
  import ppb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output proj_cfg_t         cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx = paddr[5:3];
  assign wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_COEF_U_X: cfg.u_x <= pwdata[31:0];
        REG_COEF_U_Y: cfg.u_y <= pwdata[31:0];
        REG_COEF_U_Z: cfg.u_z <= pwdata[31:0];
        REG_COEF_V_X: cfg.v_x <= pwdata[31:0];
        REG_COEF_V_Y: cfg.v_y <= pwdata[31:0];
        REG_COEF_V_Z: cfg.v_z <= pwdata[31:0];
        REG_OFFSET_U: cfg.off_u <= pwdata[55:0];
        REG_OFFSET_V: cfg.off_v <= pwdata[55:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_COEF_U_X: prdata = {32'b0, cfg.u_x};
      REG_COEF_U_Y: prdata = {32'b0, cfg.u_y};
      REG_COEF_U_Z: prdata = {32'b0, cfg.u_z};
      REG_COEF_V_X: prdata = {32'b0, cfg.v_x};
      REG_COEF_V_Y: prdata = {32'b0, cfg.v_y};
      REG_COEF_V_Z: prdata = {32'b0, cfg.v_z};
      REG_OFFSET_U: prdata = {8'b0, cfg.off_u};
      REG_OFFSET_V: prdata = {8'b0, cfg.off_v};
      default:      prdata = '0;
    endcase
  end

endmodule

[design/ppb_front.sv]
// Front end: projection, flooring, range check and address forming, four stages.
module ppb_front
  import ppb_pkg::*;
#(
  parameter int FRAME_X    = FRAME_X_DEF,
  parameter int FRAME_Y    = FRAME_Y_DEF,
  parameter int COMPONENTS = COMPONENTS_DEF,
  parameter int COEF_FRAC  = COEF_FRAC_DEF,
  localparam int NPIX   = FRAME_X * FRAME_Y,
  localparam int NCELL  = COMPONENTS * NPIX,
  localparam int TW     = (NPIX > 1) ? $clog2(NPIX) : 1,
  localparam int CW     = (NCELL > 1) ? $clog2(NCELL) : 1,
  localparam int ITEM_W = 4 + 16 + TW + CW + 33
)
(
  input  logic              clk,
  input  logic              rst,
  input  proj_cfg_t         cfg,
  input  logic              take,
  input  logic              cmd,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic signed [23:0] pos_z,
  input  logic [31:0]       luminosity,
  input  logic [16:0]       transmission,
  input  logic              is_stellar,
  input  logic [2:0]        component,
  input  logic [3:0]        read_frame,
  input  logic [15:0]       read_pixel,
  output logic [2:0]        in_flight,
  output logic              push,
  output logic [ITEM_W-1:0] push_item
);

  localparam int SW = 58;
  localparam int DW = 59;
  localparam int QW = DW - COEF_FRAC;
  localparam int XW = (FRAME_X > 1) ? $clog2(FRAME_X) : 1;
  localparam int YW = (FRAME_Y > 1) ? $clog2(FRAME_Y) : 1;
  localparam int PW = (TW > 16) ? TW : 16;

  typedef struct packed {
    logic          is_read;
    logic          hit;
    logic          use_t;
    logic          use_c;
    logic [15:0]   pix;
    logic [TW-1:0] ta;
    logic [CW-1:0] ca;
    logic [32:0]   weight;
  } item_t;

  // stage 1
  logic               v1, cmd1, st1;
  logic signed [55:0] pux1, puy1, puz1, pvx1, pvy1, pvz1;
  logic [48:0]        wp1;
  logic [2:0]         comp1;
  logic [3:0]         rf1;
  logic [15:0]        rp1;
  logic [16:0]        trc;
  // stage 2
  logic               v2, cmd2, st2;
  logic signed [SW-1:0] su2, sv2;
  logic [32:0]        w2;
  logic [2:0]         comp2;
  logic [3:0]         rf2;
  logic [15:0]        rp2;
  logic [48:0]        wr2;
  // stage 3
  logic               v3, cmd3, st3, hit3;
  logic [XW-1:0]      i3;
  logic [YW-1:0]      j3;
  logic [32:0]        w3;
  logic [2:0]         comp3;
  logic [3:0]         rf3;
  logic [15:0]        rp3;
  logic signed [DW-1:0] du, dv;
  logic [QW-1:0]      qu, qv;
  logic               inu, inv;
  // stage 4
  logic               v4;
  item_t              it4, it_n;
  logic [PW-1:0]      pix_n;
  logic [CW-1:0]      cpix;

  assign trc = (transmission > 17'd65536) ? 17'd65536 : transmission;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    cmd1  <= cmd;
    st1   <= is_stellar;
    comp1 <= component;
    rf1   <= read_frame;
    rp1   <= read_pixel;
    pux1  <= cfg.u_x * pos_x;
    puy1  <= cfg.u_y * pos_y;
    puz1  <= cfg.u_z * pos_z;
    pvx1  <= cfg.v_x * pos_x;
    pvy1  <= cfg.v_y * pos_y;
    pvz1  <= cfg.v_z * pos_z;
    wp1   <= 49'(luminosity) * 49'(trc);
  end

  assign wr2 = wp1 + 49'd32768;

  always_ff @(posedge clk) begin
    cmd2  <= cmd1;
    st2   <= st1;
    comp2 <= comp1;
    rf2   <= rf1;
    rp2   <= rp1;
    su2   <= SW'(pux1) + SW'(puy1) + SW'(puz1);
    sv2   <= SW'(pvx1) + SW'(pvy1) + SW'(pvz1);
    w2    <= wr2[48:16];
  end

  assign du  = DW'(su2) - DW'(cfg.off_u);
  assign dv  = DW'(sv2) - DW'(cfg.off_v);
  assign qu  = du[DW-1:COEF_FRAC];
  assign qv  = dv[DW-1:COEF_FRAC];
  assign inu = !du[DW-1] && (qu < QW'(FRAME_X));
  assign inv = !dv[DW-1] && (qv < QW'(FRAME_Y));

  always_ff @(posedge clk) begin
    cmd3  <= cmd2;
    st3   <= st2;
    comp3 <= comp2;
    rf3   <= rf2;
    rp3   <= rp2;
    w3    <= w2;
    hit3  <= inu & inv;
    i3    <= qu[XW-1:0];
    j3    <= qv[YW-1:0];
  end

  always_comb begin
    pix_n = PW'(i3) + PW'(FRAME_X) * PW'(j3);
    cpix  = CW'(pix_n[TW-1:0]);
    it_n  = '0;
    it_n.weight = w3;
    if (cmd3 == CMD_DETECT) begin
      it_n.hit   = hit3;
      it_n.use_t = hit3;
      it_n.use_c = hit3 && st3 && (7'(comp3) < 7'(COMPONENTS));
      it_n.pix   = hit3 ? pix_n[15:0] : 16'd0;
      it_n.ta    = pix_n[TW-1:0];
      it_n.ca    = CW'(comp3) * CW'(NPIX) + cpix;
    end else begin
      it_n.is_read = 1'b1;
      it_n.use_t = (25'(rp3) < 25'(NPIX)) && (rf3 == 4'd0);
      it_n.use_c = (25'(rp3) < 25'(NPIX)) && (rf3 != 4'd0)
                   && (8'(rf3) <= 8'(COMPONENTS));
      it_n.ta    = TW'(rp3);
      it_n.ca    = CW'(rf3 - 4'd1) * CW'(NPIX) + CW'(rp3);
    end
  end

  always_ff @(posedge clk) begin
    it4 <= it_n;
  end

  assign push      = v4;
  assign push_item = it4;
  assign in_flight = 3'(v1) + 3'(v2) + 3'(v3) + 3'(v4);

endmodule

[design/ppb_fifo.sv]
// Short queue between front and back end.
module ppb_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head,
  output logic [AW:0]  count
);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp, rp;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_data;
  end

  assign head = mem[rp];

endmodule

[design/ppb_back.sv]
// Back end: frame memories, clearing pass, read-modify-write with forwarding.
module ppb_back
  import ppb_pkg::*;
#(
  parameter int FRAME_X    = FRAME_X_DEF,
  parameter int FRAME_Y    = FRAME_Y_DEF,
  parameter int COMPONENTS = COMPONENTS_DEF,
  parameter int ACC_WIDTH  = ACC_WIDTH_DEF,
  localparam int NPIX   = FRAME_X * FRAME_Y,
  localparam int NCELL  = COMPONENTS * NPIX,
  localparam int TW     = (NPIX > 1) ? $clog2(NPIX) : 1,
  localparam int CW     = (NCELL > 1) ? $clog2(NCELL) : 1,
  localparam int ITEM_W = 4 + 16 + TW + CW + 33
)
(
  input  logic              clk,
  input  logic              rst,
  input  logic              avail,
  input  logic [ITEM_W-1:0] head,
  output logic              pop,
  output logic              clearing,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              hit,
  output logic [15:0]       pixel_index,
  output logic [47:0]       frame_value,
  output logic              saturated
);

  localparam int SUMW = ((ACC_WIDTH > 33) ? ACC_WIDTH : 33) + 1;
  localparam logic [ACC_WIDTH-1:0] ACC_MAX = '1;

  typedef struct packed {
    logic          is_read;
    logic          hit;
    logic          use_t;
    logic          use_c;
    logic [15:0]   pix;
    logic [TW-1:0] ta;
    logic [CW-1:0] ca;
    logic [32:0]   weight;
  } item_t;

  logic [ACC_WIDTH-1:0] tmem [NPIX];
  logic [ACC_WIDTH-1:0] cmem [NCELL];

  item_t                hd, b2;
  logic                 b2v, b2_go;
  logic [ACC_WIDTH-1:0] trd, crd, tfd, cfd, tcur, ccur, tnew, cnew, fsel;
  logic                 tfwd, cfwd, tsat, csat;
  logic [SUMW-1:0]      tsum, csum;
  logic                 t_we, c_we;
  logic [TW-1:0]        t_wa;
  logic [CW-1:0]        c_wa;
  logic [ACC_WIDTH-1:0] t_wd, c_wd;
  logic [CW-1:0]        clr;
  logic [ACC_WIDTH+47:0] fwide;

  assign hd    = head;
  assign b2_go = b2v && (!out_valid || out_ready);
  assign pop   = avail && !clearing && (!b2v || b2_go);

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr      <= '0;
    end else if (clearing) begin
      if (clr == CW'(NCELL - 1)) clearing <= 1'b0;
      else clr <= clr + 1'b1;
    end
  end

  assign tcur = tfwd ? tfd : trd;
  assign ccur = cfwd ? cfd : crd;
  assign tsum = SUMW'(tcur) + SUMW'(b2.weight);
  assign csum = SUMW'(ccur) + SUMW'(b2.weight);
  assign tsat = tsum > SUMW'(ACC_MAX);
  assign csat = csum > SUMW'(ACC_MAX);
  assign tnew = tsat ? ACC_MAX : tsum[ACC_WIDTH-1:0];
  assign cnew = csat ? ACC_MAX : csum[ACC_WIDTH-1:0];

  always_comb begin
    if (clearing) begin
      t_we = (CW'(clr) < CW'(NPIX));
      t_wa = clr[TW-1:0];
      t_wd = '0;
      c_we = 1'b1;
      c_wa = clr;
      c_wd = '0;
    end else begin
      t_we = b2_go && !b2.is_read && b2.use_t;
      t_wa = b2.ta;
      t_wd = tnew;
      c_we = b2_go && !b2.is_read && b2.use_c;
      c_wa = b2.ca;
      c_wd = cnew;
    end
  end

  always_ff @(posedge clk) begin
    if (t_we) tmem[t_wa] <= t_wd;
    if (pop) trd <= tmem[hd.ta];
  end

  always_ff @(posedge clk) begin
    if (c_we) cmem[c_wa] <= c_wd;
    if (pop) crd <= cmem[hd.ca];
  end

  // a write landing on the same edge as the read is missed by it
  always_ff @(posedge clk) begin
    if (pop) begin
      b2   <= hd;
      tfwd <= t_we && (t_wa == hd.ta);
      tfd  <= t_wd;
      cfwd <= c_we && (c_wa == hd.ca);
      cfd  <= c_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b2v       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) b2v <= 1'b1;
      else if (b2_go) b2v <= 1'b0;
      if (b2_go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    if (b2.use_t) fsel = tcur;
    else if (b2.use_c) fsel = ccur;
    else fsel = '0;
  end

  assign fwide = {48'b0, fsel};

  always_ff @(posedge clk) begin
    if (b2_go) begin
      if (b2.is_read) begin
        hit         <= 1'b0;
        pixel_index <= 16'd0;
        saturated   <= 1'b0;
        frame_value <= fwide[47:0];
      end else begin
        hit         <= b2.hit;
        pixel_index <= b2.pix;
        saturated   <= (b2.use_t && tsat) || (b2.use_c && csat);
        frame_value <= 48'd0;
      end
    end
  end

endmodule
